// File: src/xsfw_pkg.sv
// shared constants, types and tables of the xorshift fill word generator
`default_nettype none

package xsfw_pkg;

	localparam int WORDS_PER_INTERVAL = 64;
	localparam int OFF_W              = $clog2(WORDS_PER_INTERVAL);
	localparam int NZ_W               = $clog2(WORDS_PER_INTERVAL + 1);
	localparam int WORD_W             = 64;
	localparam int FILL_W             = 29;
	localparam int PCT_W              = 7;
	localparam int PCT_ENTRIES        = 1 << PCT_W;
	localparam int PCT_FULL           = 100;
	localparam int CFG_IDX_W          = 2;

	localparam int SHIFT_A_LEFT  = 23;
	localparam int SHIFT_A_RIGHT = 17;
	localparam int SHIFT_B_RIGHT = 26;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEED_FIRST     = 2'd0,
		CFG_SEED_SECOND    = 2'd1,
		CFG_FILL_WORDS     = 2'd2,
		CFG_RANDOM_PERCENT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic load_a;
		logic load_b;
		logic step;
	} gen_ctrl_t;

	typedef logic [NZ_W-1:0] nz_table_t [PCT_ENTRIES];

	// zero words at the head of each whole interval, none at or above full percent
	function automatic nz_table_t build_nz_table();
		nz_table_t tab;
		for (int p = 0; p < PCT_ENTRIES; p++) begin
			if (p >= PCT_FULL)
				tab[p] = '0;
			else
				tab[p] = NZ_W'((WORDS_PER_INTERVAL * (PCT_FULL - p)) / PCT_FULL);
		end
		return tab;
	endfunction

	localparam nz_table_t NZ_TABLE = build_nz_table();

endpackage

`default_nettype wire

// File: src/xsfw_gen.sv
// xorshift128+ state words with seed load and one-step advance
`default_nettype none

module xsfw_gen
	import xsfw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gen_ctrl_t         ctrl,
	input  wire logic [WORD_W-1:0] seed,
	output logic      [WORD_W-1:0] value
);

	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] s1_mix;
	logic [WORD_W-1:0] b_next;

	always_comb begin
		s1_mix = a_q ^ (a_q << SHIFT_A_LEFT);
		b_next = s1_mix ^ b_q ^ (s1_mix >> SHIFT_A_RIGHT) ^ (b_q >> SHIFT_B_RIGHT);
		value  = b_next + b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= WORD_W'(1);
			b_q <= WORD_W'(2);
		end else if (ctrl.load_a) begin
			a_q <= seed;
		end else if (ctrl.load_b) begin
			b_q <= seed;
		end else if (ctrl.step) begin
			a_q <= b_q;
			b_q <= b_next;
		end
	end

endmodule

`default_nettype wire

// File: src/xorshift_fill_word_generator_unit.sv
// top level of the xorshift fill word generator
`default_nettype none

// xorshift128+ word source with a buffer fill mode. Every input beat yields
// exactly one output beat, in the cycle after it is accepted; a new beat can
// be taken every cycle unless output is held back, as the whole generator
// step and fill position update sit between the input handshake and the single
// output register. tuser selects a plain draw (0) or the next fill word (1);
// tdata bit 0 restarts the fill at word 0. tlast marks the last word of a fill
// buffer. Zeroed fill words leave the generator untouched. Writing either seed
// register reloads the matching state word; the port never stalls.
module xorshift_fill_word_generator_unit
	import xsfw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data,
	// request beats
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,  // [0] first_word, rest zero
	input  wire logic                 s_tuser,  // [0] req_type
	// result beats
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [WORD_W-1:0]    m_tdata,  // [63:0] word_value
	output logic                      m_tlast   // last_word
);

	logic [FILL_W-1:0] fill_words_q;
	logic [PCT_W-1:0]  pct_q;
	logic [FILL_W-1:0] pos_q;
	logic [FILL_W-1:0] base_q;
	logic [OFF_W-1:0]  off_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_last_q;

	logic              cfg_fire;
	logic              in_fire;
	logic              is_fill;
	logic              restart;
	logic [FILL_W-1:0] pos;
	logic [FILL_W-1:0] base;
	logic [OFF_W-1:0]  off;
	logic [FILL_W:0]   pos_inc;
	logic              whole_iv;
	logic [NZ_W-1:0]   n_zeros;
	logic              zero_word;
	logic              last;
	logic [WORD_W-1:0] gen_value;
	gen_ctrl_t         gen_ctrl;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign s_tready  = !out_valid_q || m_tready;
	assign in_fire   = s_tvalid && s_tready;
	assign is_fill   = s_tuser;
	assign restart   = s_tdata[0];

	always_comb begin
		pos      = restart ? '0 : pos_q;
		base     = restart ? '0 : base_q;
		off      = restart ? '0 : off_q;
		pos_inc  = {1'b0, pos} + (FILL_W+1)'(1);
		// current interval is whole when it ends within the buffer
		whole_iv = ({1'b0, base} + (FILL_W+1)'(WORDS_PER_INTERVAL)) <= {1'b0, fill_words_q};
		n_zeros  = NZ_TABLE[pct_q];
		zero_word = is_fill && whole_iv && ((NZ_W+1)'(off) < (NZ_W+1)'(n_zeros));
		last     = is_fill && (pos_inc >= {1'b0, fill_words_q});

		gen_ctrl.load_a = cfg_fire && (cfg_reg_t'(cfg_index) == CFG_SEED_FIRST);
		gen_ctrl.load_b = cfg_fire && (cfg_reg_t'(cfg_index) == CFG_SEED_SECOND);
		gen_ctrl.step   = in_fire && !zero_word;
	end

	xsfw_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (gen_ctrl),
		.seed   (cfg_data),
		.value  (gen_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_words_q <= FILL_W'(64);
			pct_q        <= PCT_W'(PCT_FULL);
		end else if (cfg_fire) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FILL_WORDS:     fill_words_q <= cfg_data[FILL_W-1:0];
				CFG_RANDOM_PERCENT: pct_q        <= cfg_data[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// fill position with its interval start and offset kept alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			base_q <= '0;
			off_q  <= '0;
		end else if (in_fire && is_fill) begin
			if (last) begin
				pos_q  <= '0;
				base_q <= '0;
				off_q  <= '0;
			end else begin
				pos_q <= pos_inc[FILL_W-1:0];
				if (off == OFF_W'(WORDS_PER_INTERVAL - 1)) begin
					base_q <= base + FILL_W'(WORDS_PER_INTERVAL);
					off_q  <= '0;
				end else begin
					off_q <= off + OFF_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_word_q <= zero_word ? '0 : gen_value;
			out_last_q <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire
